@@ hdl/bgfd_pkg.sv @@
package bgfd_pkg;

  // largest payload length a header may carry
  localparam int PAYLOAD_LIMIT = 304;
  localparam int LEN_W         = $clog2(PAYLOAD_LIMIT + 1);
  localparam int CFG_LEN_W     = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int FLEN_W        = 9;

  // sync word characters
  localparam logic [7:0] SYNC_DOLLAR = 8'h24;
  localparam logic [7:0] SYNC_B      = 8'h42;
  localparam logic [7:0] SYNC_I      = 8'h49;
  localparam logic [7:0] SYNC_N      = 8'h4E;

  // message type codes
  localparam logic [15:0] TYPE_ONE     = 16'd1;
  localparam logic [15:0] TYPE_TWO     = 16'd2;
  localparam logic [15:0] TYPE_EIGHTY  = 16'd80;
  localparam logic [15:0] TYPE_LOG_LO  = 16'd93;
  localparam logic [15:0] TYPE_LOG_HI  = 16'd98;
  localparam logic [15:0] TYPE_NINETY9 = 16'd99;
  localparam logic [15:0] TYPE_MAX     = 16'd99;

  // register reset values
  localparam logic [CFG_LEN_W-1:0] TYPE1_LEN_RST  = CFG_LEN_W'(52);
  localparam logic [CFG_LEN_W-1:0] TYPE99_LEN_RST = CFG_LEN_W'(304);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TYPE1_LEN  = 2'd0,
    REG_TYPE99_LEN = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_SYNC_B,
    PH_SYNC_I,
    PH_SYNC_N,
    PH_TYPE_LO,
    PH_TYPE_HI,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_LO,
    PH_CK_HI,
    PH_TRAIL_1,
    PH_TRAIL_2
  } phase_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CLS_TYPE1  = 2'd0,
    CLS_TYPE99 = 2'd1,
    CLS_LOGGED = 2'd2,
    CLS_NONE   = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    ST_GOOD    = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_BAD_CK  = 3'd3,
    ST_BAD_HDR = 3'd4
  } status_t;

  // one result item
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data_byte;
    cls_t              msg_class;
    status_t           frame_status;
    logic [FLEN_W-1:0] frame_length;
    logic              last;
  } res_t;

  // push side of the queue
  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  // header length saturated to the result field
  function automatic logic [FLEN_W-1:0] sat_len(input logic [15:0] n);
    logic [FLEN_W-1:0] r;
    if (n > 16'((1 << FLEN_W) - 1)) begin
      r = '1;
    end else begin
      r = n[FLEN_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/bgfd_in_if.sv @@
interface bgfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

@@ hdl/bgfd_out_if.sv @@
interface bgfd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] msg_class;
  logic [2:0] frame_status;
  logic [8:0] frame_length;
  logic       last;

  modport source (output valid, output kind, output data_byte, output msg_class,
                  output frame_status, output frame_length, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input msg_class,
                input frame_status, input frame_length, input last, output ready);
endinterface

@@ hdl/bgfd_cfg_if.sv @@
interface bgfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/bin_gps_frame_deframer_unit.sv @@
// Byte-serial deframer for "$BIN" binary GPS messages. One byte is taken per
// clock while the result queue is not full; the parser front end classifies
// each byte in the cycle it arrives, so the sustained rate is one byte per
// cycle, set by the byte-wise parser state machine and its 16-bit sum. Results
// (payload bytes and one status per frame or bad header) pass through a
// two-entry queue and an output register before they show on the output.
// in_ch.ready drops only when the queue is full because the output is held.
// Configuration writes are always taken and must be made while idle.
module bin_gps_frame_deframer_unit (
  input logic         clk,
  input logic         rst_n,
  bgfd_in_if.sink     in_ch,
  bgfd_out_if.source  out_ch,
  bgfd_cfg_if.sink    cfg_ch
);
  import bgfd_pkg::*;

  push_t push;
  logic  q_full, q_not_empty, q_pop;
  res_t  q_head, out_res;

  assign cfg_ch.ready = 1'b1;

  // parser front end
  bgfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.in_byte),
    .q_full    (q_full),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .push      (push)
  );

  // result queue
  bgfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // output stage
  bgfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_res     (out_res)
  );

  assign out_ch.kind         = out_res.kind;
  assign out_ch.data_byte    = out_res.data_byte;
  assign out_ch.msg_class    = out_res.msg_class;
  assign out_ch.frame_status = out_res.frame_status;
  assign out_ch.frame_length = out_res.frame_length;
  assign out_ch.last         = out_res.last;

endmodule

@@ hdl/bgfd_front.sv @@
module bgfd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [7:0]                 in_byte,
  input  logic                       q_full,
  output logic                       in_ready,
  input  logic                       cfg_valid,
  input  logic [bgfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgfd_pkg::CFG_LEN_W-1:0] cfg_data,
  output bgfd_pkg::push_t            push
);
  import bgfd_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [15:0]          type_r, type_nxt;
  logic [7:0]           len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]     plen_r, plen_nxt;
  logic [LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [15:0]          sum_r, sum_nxt;
  logic [7:0]           ck_lo_r, ck_lo_nxt;
  logic [CFG_LEN_W-1:0] t1_len_r, t99_len_r;

  logic        accept;
  logic [15:0] plen16;
  logic [15:0] ck;
  logic [15:0] plen_ext;
  res_t        res;
  logic        emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign plen16   = {in_byte, len_lo_r};
  assign ck       = {in_byte, ck_lo_r};
  assign plen_ext = 16'(plen_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_len_r  <= TYPE1_LEN_RST;
      t99_len_r <= TYPE99_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TYPE1_LEN:  t1_len_r  <= cfg_data;
        REG_TYPE99_LEN: t99_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      type_r   <= '0;
      len_lo_r <= '0;
      plen_r   <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
      ck_lo_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_lo_r <= len_lo_nxt;
      plen_r   <= plen_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      ck_lo_r  <= ck_lo_nxt;
    end
  end

  // byte classification and result build
  always_comb begin
    phase_nxt        = phase_r;
    type_nxt         = type_r;
    len_lo_nxt       = len_lo_r;
    plen_nxt         = plen_r;
    cnt_nxt          = cnt_r;
    sum_nxt          = sum_r;
    ck_lo_nxt        = ck_lo_r;
    emit             = 1'b0;
    res.kind         = KIND_STATUS;
    res.data_byte    = '0;
    res.msg_class    = CLS_NONE;
    res.frame_status = ST_GOOD;
    res.frame_length = sat_len(plen_ext);
    res.last         = 1'b1;
    case (phase_r)
      PH_HUNT: begin
        if (in_byte == SYNC_DOLLAR) phase_nxt = PH_SYNC_B;
      end
      PH_SYNC_B, PH_SYNC_I, PH_SYNC_N: begin
        if ((phase_r == PH_SYNC_B && in_byte == SYNC_B) ||
            (phase_r == PH_SYNC_I && in_byte == SYNC_I) ||
            (phase_r == PH_SYNC_N && in_byte == SYNC_N)) begin
          phase_nxt = (phase_r == PH_SYNC_B) ? PH_SYNC_I :
                      (phase_r == PH_SYNC_I) ? PH_SYNC_N : PH_TYPE_LO;
        end else if (in_byte == SYNC_DOLLAR) begin
          phase_nxt = PH_SYNC_B;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_TYPE_LO: begin
        type_nxt  = {8'h00, in_byte};
        phase_nxt = PH_TYPE_HI;
      end
      PH_TYPE_HI: begin
        type_nxt  = {in_byte, type_r[7:0]};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_lo_nxt = in_byte;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        plen_nxt = plen16[LEN_W-1:0];
        cnt_nxt  = '0;
        sum_nxt  = '0;
        if (type_r > TYPE_MAX || plen16 > 16'(PAYLOAD_LIMIT)) begin
          phase_nxt        = PH_HUNT;
          emit             = 1'b1;
          res.frame_status = ST_BAD_HDR;
          res.frame_length = sat_len(plen16);
        end else if (plen16 == 16'd0) begin
          phase_nxt = PH_CK_LO;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt = sum_r + 16'(in_byte);
        cnt_nxt = cnt_r + LEN_W'(1);
        if (cnt_nxt >= plen_r) phase_nxt = PH_CK_LO;
        emit          = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = in_byte;
        res.last      = 1'b0;
      end
      PH_CK_LO: begin
        ck_lo_nxt = in_byte;
        phase_nxt = PH_CK_HI;
      end
      PH_CK_HI: begin
        emit = 1'b1;
        if (ck != sum_r) begin
          phase_nxt        = PH_HUNT;
          res.frame_status = ST_BAD_CK;
        end else begin
          phase_nxt = PH_TRAIL_1;
          if (type_r == TYPE_ONE) begin
            if (plen_ext == 16'(t1_len_r)) res.msg_class = CLS_TYPE1;
            else res.frame_status = ST_BAD_LEN;
          end else if (type_r == TYPE_NINETY9) begin
            if (plen_ext == 16'(t99_len_r)) res.msg_class = CLS_TYPE99;
            else res.frame_status = ST_BAD_LEN;
          end else if (type_r == TYPE_TWO || type_r == TYPE_EIGHTY ||
                       (type_r >= TYPE_LOG_LO && type_r <= TYPE_LOG_HI)) begin
            res.msg_class = CLS_LOGGED;
          end else begin
            res.frame_status = ST_UNKNOWN;
          end
        end
      end
      PH_TRAIL_1: begin
        phase_nxt = PH_TRAIL_2;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  assign push.valid = accept && emit;
  assign push.res   = res;

endmodule

@@ hdl/bgfd_queue.sv @@
module bgfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  bgfd_pkg::push_t  push,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output bgfd_pkg::res_t   head
);
  import bgfd_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push.valid) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) slot_r[wr_ptr_r] <= push.res;
  end

endmodule

@@ hdl/bgfd_back.sv @@
module bgfd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  bgfd_pkg::res_t  q_head,
  output logic            q_pop,
  input  logic            out_ready,
  output logic            out_valid,
  output bgfd_pkg::res_t  out_res
);
  import bgfd_pkg::*;

  logic valid_r;
  res_t res_r;

  // load when the output register is free or being drained
  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_head;
  end

endmodule
